FILE: rtl/core/dia_pkg.sv
package dia_pkg;

  localparam int HEAP_DEPTH  = 1024;
  localparam int PTR_W       = $clog2(HEAP_DEPTH);
  localparam int FILL_W      = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W       = 11;
  localparam int CNT_W       = 11;
  localparam int RES_W       = 10;
  localparam int STRIDE_W    = 16;
  localparam int ADDR_W      = 64;
  localparam int OFF_W       = IDX_W + STRIDE_W;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 144;

  localparam logic [IDX_W-1:0] SLOT_NONE = IDX_W'(1024);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GPU     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC       = 3'd0,
    CMD_ALLOC_RANGE = 3'd1,
    CMD_FREE        = 3'd2,
    CMD_FREE_RANGE  = 3'd3,
    CMD_RESET       = 3'd4,
    CMD_TRANSLATE   = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOSPACE  = 3'd1,
    ST_OVERFLOW = 3'd2,
    ST_RANGE    = 3'd3,
    ST_NONE     = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic             none;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    cap;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   cpu_base;
    logic [ADDR_W-1:0]   gpu_base;
    logic                visible;
  } cfg_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [IDX_W-1:0]  next_unused;
    logic              reset_taken;
  } stat_t;

  function automatic logic [PTR_W-1:0] adv_ptr(input logic [PTR_W-1:0] p);
    adv_ptr = (p == PTR_W'(HEAP_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

FILE: rtl/core/dia_ram.sv
module dia_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/dia_front.sv
module dia_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [dia_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [dia_pkg::CMD_W-1:0]     s_axis_tuser_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output dia_pkg::req_t                 push_req_o
);
  import dia_pkg::*;

  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt;

  assign idx = s_axis_tdata_i[IDX_W-1:0];
  assign cnt = s_axis_tdata_i[IDX_W+CNT_W-1:IDX_W];

  // decode and tag the none index so the back end sees a none flag
  always_comb begin
    push_req_o.cmd  = cmd_e'(s_axis_tuser_i);
    push_req_o.none = (idx == SLOT_NONE);
    push_req_o.idx  = idx;
    push_req_o.cnt  = cnt;
  end

  assign push_valid_o    = s_axis_tvalid_i;
  assign s_axis_tready_o = push_ready_i;

endmodule

FILE: rtl/core/dia_queue.sv
module dia_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  dia_pkg::req_t push_req_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output dia_pkg::req_t pop_req_o
);
  import dia_pkg::*;

  req_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_req_o    = entry_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_req_i;
    end
  end

endmodule

FILE: rtl/core/dia_back.sv
module dia_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dia_pkg::cfg_t                cfg_i,
  input  logic                         req_valid_i,
  output logic                         req_ready_o,
  input  dia_pkg::req_t                req_i,
  output logic                         m_valid_o,
  input  logic                         m_ready_i,
  output logic [dia_pkg::STATUS_W-1:0] m_status_o,
  output logic [dia_pkg::RES_W-1:0]    m_res_o,
  output logic [dia_pkg::ADDR_W-1:0]   m_cpu_o,
  output logic [dia_pkg::ADDR_W-1:0]   m_gpu_o,
  output dia_pkg::stat_t               stat_o
);
  import dia_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  tail_q, tail_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  nu_q, nu_d;
  logic              out_valid_q, out_valid_d;

  status_e           status_q, status_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic [IDX_W-1:0]  midx_q, midx_d;
  logic              addr_en_q, addr_en_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [IDX_W-1:0]  walk_k_q, walk_k_d;
  logic [CNT_W-1:0]  walk_left_q, walk_left_d;
  logic              drop_q, drop_d;
  status_e           out_status_q, out_status_d;
  logic [RES_W-1:0]  out_res_q, out_res_d;
  logic [ADDR_W-1:0] out_cpu_q, out_cpu_d;
  logic [ADDR_W-1:0] out_gpu_q, out_gpu_d;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_waddr;
  logic [PTR_W-1:0]  ram_wdata;
  logic [PTR_W-1:0]  ram_rdata;
  logic              fifo_full;
  logic              reset_taken;
  logic [IDX_W:0]    range_end;
  logic [ADDR_W-1:0] off_ext;

  assign fifo_full = (fill_q == FILL_W'(HEAP_DEPTH));
  assign range_end = {1'b0, nu_q} + {1'b0, req_i.cnt};
  assign off_ext   = ADDR_W'(off_q);

  dia_ram #(
    .WIDTH (PTR_W),
    .DEPTH (HEAP_DEPTH)
  ) u_free_list (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    fill_d       = fill_q;
    nu_d         = nu_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    status_d     = status_q;
    res_d        = res_q;
    midx_d       = midx_q;
    addr_en_d    = addr_en_q;
    off_d        = off_q;
    walk_k_d     = walk_k_q;
    walk_left_d  = walk_left_q;
    drop_d       = drop_q;
    out_status_d = out_status_q;
    out_res_d    = out_res_q;
    out_cpu_d    = out_cpu_q;
    out_gpu_d    = out_gpu_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = tail_q;
    ram_wdata    = '0;
    reset_taken  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          status_d  = ST_OK;
          res_d     = '0;
          addr_en_d = 1'b0;
          state_d   = S_DONE;
          case (req_i.cmd)
            CMD_ALLOC: begin
              if (fill_q != '0) begin
                ram_re    = 1'b1;
                head_d    = adv_ptr(head_q);
                fill_d    = fill_q - FILL_W'(1);
                addr_en_d = 1'b1;
                state_d   = S_READ;
              end else if (nu_q >= cfg_i.cap) begin
                status_d = ST_NOSPACE;
              end else begin
                res_d     = nu_q[RES_W-1:0];
                midx_d    = nu_q;
                nu_d      = nu_q + IDX_W'(1);
                addr_en_d = 1'b1;
                state_d   = S_MUL;
              end
            end
            CMD_ALLOC_RANGE: begin
              if (nu_q >= cfg_i.cap || range_end > {1'b0, cfg_i.cap}) begin
                status_d = ST_NOSPACE;
              end else begin
                res_d     = nu_q[RES_W-1:0];
                midx_d    = nu_q;
                nu_d      = range_end[IDX_W-1:0];
                addr_en_d = 1'b1;
                state_d   = S_MUL;
              end
            end
            CMD_FREE: begin
              if (req_i.none) begin
                status_d = ST_NONE;
              end else if (req_i.idx >= cfg_i.cap) begin
                status_d = ST_RANGE;
              end else if (fifo_full) begin
                status_d = ST_OVERFLOW;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = req_i.idx[PTR_W-1:0];
                tail_d    = adv_ptr(tail_q);
                fill_d    = fill_q + FILL_W'(1);
              end
            end
            CMD_FREE_RANGE: begin
              if (req_i.none) begin
                status_d = ST_NONE;
              end else begin
                walk_k_d    = req_i.idx;
                walk_left_d = req_i.cnt;
                drop_d      = 1'b0;
                state_d     = S_WALK;
              end
            end
            CMD_RESET: begin
              head_d      = '0;
              tail_d      = '0;
              fill_d      = '0;
              nu_d        = '0;
              reset_taken = 1'b1;
            end
            CMD_TRANSLATE: begin
              if (req_i.none) begin
                status_d = ST_NONE;
              end else begin
                if (req_i.idx >= cfg_i.cap) begin
                  status_d = ST_RANGE;
                end
                midx_d    = req_i.idx;
                addr_en_d = 1'b1;
                state_d   = S_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        res_d   = ram_rdata;
        midx_d  = IDX_W'(ram_rdata);
        state_d = S_MUL;
      end
      S_MUL: begin
        off_d   = OFF_W'(midx_q) * OFF_W'(cfg_i.stride);
        state_d = S_DONE;
      end
      S_WALK: begin
        // indices only grow, so the first one past capacity ends the walk
        if (walk_left_q == '0) begin
          status_d = drop_q ? ST_OVERFLOW : ST_OK;
          state_d  = S_DONE;
        end else if (walk_k_q >= cfg_i.cap) begin
          status_d = ST_RANGE;
          state_d  = S_DONE;
        end else begin
          if (fifo_full) begin
            drop_d = 1'b1;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = walk_k_q[PTR_W-1:0];
            tail_d    = adv_ptr(tail_q);
            fill_d    = fill_q + FILL_W'(1);
          end
          walk_k_d    = walk_k_q + IDX_W'(1);
          walk_left_d = walk_left_q - CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_res_d    = res_q;
          out_cpu_d    = addr_en_q ? cfg_i.cpu_base + off_ext : '0;
          out_gpu_d    = (addr_en_q && cfg_i.visible) ? cfg_i.gpu_base + off_ext : '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      nu_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      nu_q        <= nu_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    res_q        <= res_d;
    midx_q       <= midx_d;
    addr_en_q    <= addr_en_d;
    off_q        <= off_d;
    walk_k_q     <= walk_k_d;
    walk_left_q  <= walk_left_d;
    drop_q       <= drop_d;
    out_status_q <= out_status_d;
    out_res_q    <= out_res_d;
    out_cpu_q    <= out_cpu_d;
    out_gpu_q    <= out_gpu_d;
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign m_valid_o   = out_valid_q;
  assign m_status_o  = out_status_q;
  assign m_res_o     = out_res_q;
  assign m_cpu_o     = out_cpu_q;
  assign m_gpu_o     = out_gpu_q;

  always_comb begin
    stat_o.fill        = fill_q;
    stat_o.next_unused = nu_q;
    stat_o.reset_taken = reset_taken;
  end

endmodule

FILE: rtl/core/descriptor_index_allocator.sv
// path: free, reset, failed allocation and none requests go from idle straight to the done
// state; translate and bump allocation pass through the multiply state, allocation from the
// free list first reads the registered free list, range free walks one index per cycle
// throughput: one request at a time in the back end, no new one until the result is registered;
// a 2-deep queue keeps taking requests while the back end is busy, until it is full
// reset: asynchronous, empties the free list and the bump pointer, registers to defaults
module descriptor_index_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // slot_index, slot_count
  input  logic [dia_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // command
  input  logic [dia_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_index, cpu_address, gpu_address
  output logic [dia_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status
  output logic [dia_pkg::STATUS_W-1:0]    m_axis_tuser,
  input  logic                            cfg_we_i,
  input  logic [dia_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dia_pkg::ADDR_W-1:0]      cfg_data_i
);
  import dia_pkg::*;

  logic [IDX_W-1:0]    slots_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [ADDR_W-1:0]   cpu_base_q;
  logic [ADDR_W-1:0]   gpu_base_q;
  logic                visible_q;
  cfg_t                cfg;

  logic              push_valid, push_ready;
  req_t              push_req;
  logic              pop_valid, pop_ready;
  req_t              pop_req;
  logic [RES_W-1:0]  res;
  logic [ADDR_W-1:0] cpu_addr, gpu_addr;
  stat_t             stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q    <= IDX_W'(1024);
      stride_q   <= STRIDE_W'(32);
      cpu_base_q <= '0;
      gpu_base_q <= '0;
      visible_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SLOTS:   slots_q    <= cfg_data_i[IDX_W-1:0];
        CFG_STRIDE:  stride_q   <= cfg_data_i[STRIDE_W-1:0];
        CFG_CPU:     cpu_base_q <= cfg_data_i;
        CFG_GPU:     gpu_base_q <= cfg_data_i;
        CFG_VISIBLE: visible_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.cap      = (slots_q < IDX_W'(HEAP_DEPTH)) ? slots_q : IDX_W'(HEAP_DEPTH);
    cfg.stride   = stride_q;
    cfg.cpu_base = cpu_base_q;
    cfg.gpu_base = gpu_base_q;
    cfg.visible  = visible_q;
  end

  dia_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_req_o      (push_req)
  );

  dia_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_req_i   (push_req),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_req_o    (pop_req)
  );

  dia_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (pop_valid),
    .req_ready_o (pop_ready),
    .req_i       (pop_req),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_status_o  (m_axis_tuser),
    .m_res_o     (res),
    .m_cpu_o     (cpu_addr),
    .m_gpu_o     (gpu_addr),
    .stat_o      (stat)
  );

  assign m_axis_tdata = {(OUT_DATA_W - RES_W - 2 * ADDR_W)'(0), gpu_addr, cpu_addr, res};

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fill <= FILL_W'(HEAP_DEPTH))
    else $error("free list fill count past heap depth");

  a_reset_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.reset_taken |=> (stat.fill == '0) && (stat.next_unused == '0))
    else $error("reset request did not empty the allocator");

  a_fail_no_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_NONE || m_axis_tuser == ST_NOSPACE)
    |-> (gpu_addr == '0) && (cpu_addr == '0) && (res == '0))
    else $error("failed or none request carries an address");

endmodule

FILE: verif/allocation_checker.sv
module allocation_checker
  import dia_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // slot_index, slot_count
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // command
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // result_index, cpu_address, gpu_address
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  // status
  input  logic [STATUS_W-1:0]   m_axis_tuser_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ADDR_W-1:0]     cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_e           status;
    logic [RES_W-1:0]  slot;
    logic [ADDR_W-1:0] cpu_addr;
    logic [ADDR_W-1:0] gpu_addr;
  } alloc_result_t;

  // shadow of the allocator state and its registers
  logic [RES_W-1:0]    free_list [HEAP_DEPTH];
  int unsigned         list_head;
  int unsigned         list_tail;
  int unsigned         list_fill;
  int unsigned         bump_ptr;
  logic [IDX_W-1:0]    heap_slots;
  logic [STRIDE_W-1:0] heap_stride;
  logic [ADDR_W-1:0]   heap_cpu_base;
  logic [ADDR_W-1:0]   heap_gpu_base;
  logic                heap_visible;

  alloc_result_t expected_results[$];

  function automatic int unsigned heap_capacity();
    return (heap_slots < HEAP_DEPTH) ? int'(heap_slots) : HEAP_DEPTH;
  endfunction

  function automatic alloc_result_t with_addresses(input alloc_result_t r,
                                                   input int unsigned slot);
    logic [ADDR_W-1:0] offset;
    offset = ADDR_W'(slot) * ADDR_W'(heap_stride);
    r.cpu_addr = heap_cpu_base + offset;
    r.gpu_addr = heap_visible ? heap_gpu_base + offset : '0;
    return r;
  endfunction

  // returns 0 when the free list is full and the index is dropped
  function automatic bit push_free(input int unsigned slot);
    if (list_fill >= HEAP_DEPTH) return 1'b0;
    free_list[list_tail] = RES_W'(slot);
    list_tail = (list_tail + 1) % HEAP_DEPTH;
    list_fill++;
    return 1'b1;
  endfunction

  function automatic alloc_result_t predict_slot_request(input logic [CMD_W-1:0] cmd,
                                                         input logic [IDX_W-1:0] idx,
                                                         input logic [CNT_W-1:0] cnt);
    alloc_result_t r;
    int unsigned   cap;
    bit            bad;
    bit            dropped;
    r = '{status: ST_OK, slot: '0, cpu_addr: '0, gpu_addr: '0};
    cap = heap_capacity();
    bad = 1'b0;
    dropped = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        if (list_fill > 0) begin
          r.slot = free_list[list_head];
          list_head = (list_head + 1) % HEAP_DEPTH;
          list_fill--;
          r = with_addresses(r, r.slot);
        end else if (bump_ptr >= cap) begin
          r.status = ST_NOSPACE;
        end else begin
          r.slot = RES_W'(bump_ptr);
          r = with_addresses(r, bump_ptr);
          bump_ptr++;
        end
      end
      CMD_ALLOC_RANGE: begin
        if (bump_ptr >= cap || bump_ptr + cnt > cap) begin
          r.status = ST_NOSPACE;
        end else begin
          r.slot = RES_W'(bump_ptr);
          r = with_addresses(r, bump_ptr);
          bump_ptr += cnt;
        end
      end
      CMD_FREE: begin
        if (idx == SLOT_NONE) r.status = ST_NONE;
        else if (idx >= cap) r.status = ST_RANGE;
        else if (!push_free(idx)) r.status = ST_OVERFLOW;
      end
      CMD_FREE_RANGE: begin
        if (idx == SLOT_NONE) begin
          r.status = ST_NONE;
        end else begin
          // each index of the range is checked on its own
          for (int unsigned i = 0; i < cnt; i++) begin
            if (idx + i >= cap) bad = 1'b1;
            else if (!push_free(idx + i)) dropped = 1'b1;
          end
          r.status = bad ? ST_RANGE : (dropped ? ST_OVERFLOW : ST_OK);
        end
      end
      CMD_RESET: begin
        list_head = 0;
        list_tail = 0;
        list_fill = 0;
        bump_ptr = 0;
      end
      CMD_TRANSLATE: begin
        if (idx == SLOT_NONE) begin
          r.status = ST_NONE;
        end else begin
          if (idx >= cap) r.status = ST_RANGE;
          r = with_addresses(r, idx);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch on result %0d: %s", $time, checked_o, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t     want;
    logic [RES_W-1:0]  got_slot;
    logic [ADDR_W-1:0] got_cpu;
    logic [ADDR_W-1:0] got_gpu;
    if (!rst_ni) begin
      list_head = 0;
      list_tail = 0;
      list_fill = 0;
      bump_ptr = 0;
      heap_slots = IDX_W'(1024);
      heap_stride = STRIDE_W'(32);
      heap_cpu_base = '0;
      heap_gpu_base = '0;
      heap_visible = 1'b0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SLOTS:   heap_slots = cfg_data_i[IDX_W-1:0];
          CFG_STRIDE:  heap_stride = cfg_data_i[STRIDE_W-1:0];
          CFG_CPU:     heap_cpu_base = cfg_data_i;
          CFG_GPU:     heap_gpu_base = cfg_data_i;
          CFG_VISIBLE: heap_visible = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_results.push_back(predict_slot_request(s_axis_tuser_i,
                                     s_axis_tdata_i[IDX_W-1:0],
                                     s_axis_tdata_i[IDX_W +: CNT_W]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_results.pop_front();
          got_slot = m_axis_tdata_i[RES_W-1:0];
          got_cpu = m_axis_tdata_i[RES_W +: ADDR_W];
          got_gpu = m_axis_tdata_i[RES_W+ADDR_W +: ADDR_W];
          if (m_axis_tuser_i != want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", m_axis_tuser_i,
                                      want.status));
          if (got_slot != want.slot)
            report_mismatch($sformatf("result_index %0d, predicted %0d", got_slot,
                                      want.slot));
          if (got_cpu != want.cpu_addr)
            report_mismatch($sformatf("cpu_address %h, predicted %h", got_cpu,
                                      want.cpu_addr));
          if (got_gpu != want.gpu_addr)
            report_mismatch($sformatf("gpu_address %h, predicted %h", got_gpu,
                                      want.gpu_addr));
          checked_o++;
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: verif/tb.sv
module tb;
  import dia_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400_000;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // slot_index, slot_count
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  // command
  logic [CMD_W-1:0]      s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // result_index, cpu_address, gpu_address
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // status
  logic [STATUS_W-1:0]   m_axis_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ADDR_W-1:0]     cfg_data;

  int fail_count;
  int pending;
  int checked;
  int send_idle_pct;
  int recv_idle_pct;
  int heap_cap;
  int cycle_count;
  int cmd_tally [8];

  descriptor_index_allocator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  allocation_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic [CNT_W-1:0] cnt);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({cnt, idx});
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    cmd_tally[cmd]++;
  endtask

  // block goes idle: nothing in flight and the input valid dropped
  task automatic wait_for_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                input logic [ADDR_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= value;
    @(posedge clk_i);
  endtask

  task automatic load_setting(input int slots, input int stride, input logic [ADDR_W-1:0] cpu,
                              input logic [ADDR_W-1:0] gpu, input bit visible);
    wait_for_drain();
    write_register(CFG_SLOTS, ADDR_W'(slots));
    write_register(CFG_STRIDE, ADDR_W'(stride));
    write_register(CFG_CPU, cpu);
    write_register(CFG_GPU, gpu);
    write_register(CFG_VISIBLE, ADDR_W'(visible));
    @(negedge clk_i);
    cfg_we <= 1'b0;
    heap_cap = (slots < HEAP_DEPTH) ? slots : HEAP_DEPTH;
  endtask

  function automatic logic [ADDR_W-1:0] random_address();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(99);
    if (r < 65 && heap_cap > 0) return IDX_W'($urandom_range(heap_cap - 1));
    if (r < 75) return SLOT_NONE;
    return IDX_W'($urandom_range(1024));
  endfunction

  // mostly short ranges, now and then a long walk
  function automatic logic [CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 85) return CNT_W'($urandom_range(8));
    if (r < 98) return CNT_W'($urandom_range(64));
    return CNT_W'($urandom_range(1024));
  endfunction

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 30)      send_request(CMD_ALLOC, pick_index(), pick_count());
    else if (r < 40) send_request(CMD_ALLOC_RANGE, pick_index(), pick_count());
    else if (r < 62) send_request(CMD_FREE, pick_index(), pick_count());
    else if (r < 72) send_request(CMD_FREE_RANGE, pick_index(), pick_count());
    else if (r < 75) send_request(CMD_RESET, pick_index(), pick_count());
    else if (r < 97) send_request(CMD_TRANSLATE, pick_index(), pick_count());
    else if (r < 98) send_request(CMD_SPARE_6, pick_index(), pick_count());
    else             send_request(CMD_SPARE_7, pick_index(), pick_count());
  endtask

  task automatic random_setting(input int k);
    case (k)
      0: load_setting(16, 65535, '1, random_address(), 1'b1);
      1: load_setting(1024, 1, '0, '1, 1'b0);
      2: load_setting(0, 1, random_address(), random_address(), 1'b1);
      3: load_setting($urandom_range(1, 1024), $urandom_range(1, 65535), random_address(),
                      random_address(), 1'($urandom_range(1)));
      4: load_setting(1, 32, random_address(), random_address(), 1'b1);
      default: load_setting(200, $urandom_range(1, 65535), random_address(),
                            random_address(), 1'b1);
    endcase
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_ALLOC;
    cfg_we        = 1'b0;
    cfg_index     = CFG_SLOTS;
    cfg_data      = '0;
    rst_ni        = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 80;
    heap_cap      = HEAP_DEPTH;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // tiny heap: bump, range, exhaustion, free-list reuse, out of range, none index
    load_setting(4, 65535, '1, 64'h8000_0000_0000_0000, 1'b1);
    send_request(CMD_ALLOC, 11'd0, 11'd0);
    send_request(CMD_ALLOC_RANGE, 11'd0, 11'd2);
    send_request(CMD_ALLOC_RANGE, 11'd0, 11'd0);
    send_request(CMD_ALLOC, 11'd0, 11'd0);
    send_request(CMD_ALLOC, 11'd0, 11'd0);
    send_request(CMD_ALLOC_RANGE, 11'd0, 11'd0);
    send_request(CMD_FREE, SLOT_NONE, 11'd0);
    send_request(CMD_FREE, 11'd4, 11'd0);
    send_request(CMD_FREE, 11'd2, 11'd0);
    send_request(CMD_ALLOC, 11'd0, 11'd0);
    send_request(CMD_FREE_RANGE, SLOT_NONE, 11'd5);
    send_request(CMD_FREE_RANGE, 11'd2, 11'd3);
    send_request(CMD_FREE_RANGE, 11'd0, 11'd0);
    send_request(CMD_TRANSLATE, SLOT_NONE, 11'd0);
    send_request(CMD_TRANSLATE, 11'd1023, 11'd1024);
    send_request(CMD_TRANSLATE, 11'd3, 11'd0);
    send_request(CMD_SPARE_6, 11'd1023, 11'd1024);
    send_request(CMD_SPARE_7, 11'd5, 11'd7);
    send_request(CMD_RESET, 11'd0, 11'd0);

    // full heap: fill the free list to overflow, then full-size range
    load_setting(1024, 1, '0, '1, 1'b0);
    send_request(CMD_FREE_RANGE, 11'd0, 11'd1024);
    send_request(CMD_FREE, 11'd5, 11'd0);
    send_request(CMD_FREE_RANGE, 11'd10, 11'd2);
    send_request(CMD_ALLOC_RANGE, 11'd0, 11'd1024);
    send_request(CMD_ALLOC, 11'd0, 11'd0);
    send_request(CMD_RESET, 11'd0, 11'd0);
    send_request(CMD_TRANSLATE, 11'd0, 11'd0);

    for (int blk = 0; blk < 6; blk++) begin
      if (blk < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 80;
      end else if (blk < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting(blk);
      for (int n = 0; n < 125; n++) begin
        // hold off until every result is back once
        if (blk == 3 && n == 60) wait_for_drain();
        random_request();
      end
    end

    wait_for_drain();
    repeat (10) @(negedge clk_i);
    $display("%0d requests (alloc %0d, range alloc %0d, free %0d, range free %0d, reset %0d,",
             cmd_tally[CMD_ALLOC] + cmd_tally[CMD_ALLOC_RANGE] + cmd_tally[CMD_FREE] +
             cmd_tally[CMD_FREE_RANGE] + cmd_tally[CMD_RESET] + cmd_tally[CMD_TRANSLATE] +
             cmd_tally[CMD_SPARE_6] + cmd_tally[CMD_SPARE_7],
             cmd_tally[CMD_ALLOC], cmd_tally[CMD_ALLOC_RANGE], cmd_tally[CMD_FREE],
             cmd_tally[CMD_FREE_RANGE], cmd_tally[CMD_RESET]);
    $display("translate %0d, undefined %0d), %0d results checked over heaps of 0 to 1024 slots",
             cmd_tally[CMD_TRANSLATE], cmd_tally[CMD_SPARE_6] + cmd_tally[CMD_SPARE_7], checked);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dia_pkg.sv
rtl/core/dia_ram.sv
rtl/core/dia_front.sv
rtl/core/dia_queue.sv
rtl/core/dia_back.sv
rtl/core/descriptor_index_allocator.sv
verif/allocation_checker.sv
verif/tb.sv
